>>> hw/rtl/ffha_pkg.sv
`default_nettype none
package ffha_pkg;
   localparam int GRAN_BYTES = 8;
   localparam int GRAN_SHIFT = 3;
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_BADPTR  = 2'd2;
   localparam logic       OP_ALLOC = 1'b0;
   localparam logic       OP_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_WR,
      ST_F_RD,
      ST_F_CHK,
      ST_F_NX_RD,
      ST_F_NX_CHK,
      ST_RESP
   } state_type;
endpackage
`default_nettype wire

>>> hw/rtl/first_fit_heap_allocator.sv
`default_nettype none
// First-fit heap allocator. The heap of HEAP_BYTES bytes is tiled by chunks,
// each an 8-byte header (payload size, allocated mark) followed by its payload;
// headers live in a single-port synchronous memory with one entry per granule.
// Allocate rounds the size up to 8 and walks the header chain from offset 0,
// taking the first free chunk that fits and splitting off the remainder when it
// exceeds one header. Free walks the chain to find the chunk, checks that it is
// allocated, then merges it with a free predecessor and with the free chunks
// that follow it up to the next allocated one. Errors return a status and leave
// the state unchanged; a null free returns ok. One result is produced per
// transfer on the req_ channel. Rate: one item at a time. Each header visited
// takes a memory read state, then a check state, followed by the split or
// merged header write and the response register; a null or out-of-range free
// goes straight to the response state. The free walk and its forward merge
// together visit each chunk at most once. After reset the block writes entry 0
// before it accepts its first item (mem entries other than written ones are
// never used).
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES = 4096
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_operation,
   input  wire  [15:0] req_request_size,
   input  wire  [11:0] req_payload_offset,
   input  wire         req_is_null,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_granted_offset,
   output logic [11:0] rsp_used_bytes,
   output logic [9:0]  rsp_used_chunks
);
   import ffha_pkg::*;

   localparam int SLOTS = HEAP_BYTES / GRAN_BYTES;
   localparam int IW    = $clog2(SLOTS);     // header index width
   localparam int AW    = IW + GRAN_SHIFT;   // byte offset width
   localparam int CW    = AW + 1;            // offsets that may reach the heap end
   localparam int SW    = AW;                // size field width
   localparam int PW    = (CW + 1 > 13) ? CW + 1 : 13;  // holds any payload offset
   localparam logic [CW-1:0] HEAP_END = CW'(HEAP_BYTES);
   localparam logic [CW-1:0] GRAN_C   = CW'(GRAN_BYTES);

   // header memory: {size, alloc}
   logic [SW:0]   mem [SLOTS];
   logic          mem_we;
   logic [IW-1:0] mem_addr;
   logic [SW:0]   mem_wdata;
   logic [SW:0]   mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   state_type     state_ff, state_in;
   logic [16:0]   size_ff, size_in;        // rounded request
   logic [CW-1:0] target_ff, target_in;    // header offset sought by free
   logic [CW-1:0] cur_ff, cur_in;
   logic [CW-1:0] prev_ff, prev_in;
   logic [SW-1:0] prev_sz_ff, prev_sz_in;
   logic          prev_free_ff, prev_free_in;
   logic          have_prev_ff, have_prev_in;
   logic [SW-1:0] acc_ff, acc_in;          // size of merged chunk
   logic [CW-1:0] split_ff, split_in;
   logic [SW-1:0] split_sz_ff, split_sz_in;
   logic [IW:0]   steps_ff, steps_in;
   logic [1:0]    status_ff, status_in;
   logic [11:0]   grant_ff, grant_in;
   logic [11:0]   bytes_ff, bytes_in;
   logic [9:0]    chunks_ff, chunks_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         bytes_ff     <= '0;
         chunks_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bytes_ff     <= bytes_in;
         chunks_ff    <= chunks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff      <= size_in;
      target_ff    <= target_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      prev_sz_ff   <= prev_sz_in;
      prev_free_ff <= prev_free_in;
      have_prev_ff <= have_prev_in;
      acc_ff       <= acc_in;
      split_ff     <= split_in;
      split_sz_ff  <= split_sz_in;
      steps_ff     <= steps_in;
      status_ff    <= status_in;
      grant_ff     <= grant_in;
   end

   logic [SW-1:0] rd_sz;
   logic          rd_alloc;
   logic [CW-1:0] nxt;
   logic [16:0]   rnd;
   logic [PW-1:0] pay_ext;

   assign rd_sz    = mem_rdata_ff[SW:1];
   assign rd_alloc = mem_rdata_ff[0];
   assign nxt      = cur_ff + GRAN_C + CW'(rd_sz);
   assign rnd      = (17'(req_request_size) + 17'(GRAN_BYTES - 1)) & ~17'(GRAN_BYTES - 1);
   assign pay_ext  = PW'(req_payload_offset);

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      target_in    = target_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_sz_in   = prev_sz_ff;
      prev_free_in = prev_free_ff;
      have_prev_in = have_prev_ff;
      acc_in       = acc_ff;
      split_in     = split_ff;
      split_sz_in  = split_sz_ff;
      steps_in     = steps_ff;
      status_in    = status_ff;
      grant_in     = grant_ff;
      bytes_in     = bytes_ff;
      chunks_in    = chunks_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mem_addr     = cur_ff[GRAN_SHIFT +: IW];
      mem_wdata    = '0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_addr  = '0;
            mem_wdata = {SW'(HEAP_BYTES - GRAN_BYTES), 1'b0};
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               size_in      = rnd;
               cur_in       = '0;
               steps_in     = '0;
               have_prev_in = 1'b0;
               grant_in     = '0;
               target_in    = CW'(pay_ext - PW'(GRAN_BYTES));
               if (req_operation == OP_ALLOC) begin
                  state_in = ST_A_RD;
               end else if (req_is_null) begin
                  status_in = STATUS_OK;
                  state_in  = ST_RESP;
               end else if (pay_ext < PW'(GRAN_BYTES)
                            || pay_ext >= PW'(HEAP_BYTES)) begin
                  status_in = STATUS_BADPTR;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_F_RD;
               end
            end
         end
         ST_A_RD: begin
            if (cur_ff >= HEAP_END || steps_ff >= (IW + 1)'(SLOTS)) begin
               status_in = STATUS_NOSPACE;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_A_CHK;
            end
         end
         ST_A_CHK: begin
            if (!rd_alloc && 17'(rd_sz) >= size_ff) begin
               mem_we    = 1'b1;
               if (17'(rd_sz) > size_ff + 17'(GRAN_BYTES)) begin
                  mem_wdata   = {SW'(size_ff), 1'b1};
                  bytes_in    = bytes_ff + 12'(size_ff);
                  split_in    = cur_ff + GRAN_C + CW'(size_ff);
                  split_sz_in = rd_sz - SW'(size_ff) - SW'(GRAN_BYTES);
                  state_in    = ST_A_WR;
               end else begin
                  mem_wdata = {rd_sz, 1'b1};
                  bytes_in  = bytes_ff + 12'(rd_sz);
                  state_in  = ST_RESP;
               end
               chunks_in = chunks_ff + 10'd1;
               status_in = STATUS_OK;
               grant_in  = 12'(cur_ff + GRAN_C);
            end else begin
               cur_in   = nxt;
               steps_in = steps_ff + (IW + 1)'(1);
               state_in = ST_A_RD;
            end
         end
         ST_A_WR: begin
            mem_we    = 1'b1;
            mem_addr  = split_ff[GRAN_SHIFT +: IW];
            mem_wdata = {split_sz_ff, 1'b0};
            state_in  = ST_RESP;
         end
         ST_F_RD: begin
            if (cur_ff >= HEAP_END || steps_ff >= (IW + 1)'(SLOTS)) begin
               status_in = STATUS_BADPTR;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            if (cur_ff == target_ff) begin
               if (!rd_alloc) begin
                  status_in = STATUS_BADPTR;
                  state_in  = ST_RESP;
               end else begin
                  status_in = STATUS_OK;
                  bytes_in  = bytes_ff - 12'(rd_sz);
                  chunks_in = chunks_ff - 10'd1;
                  if (have_prev_ff && prev_free_ff) begin
                     acc_in = prev_sz_ff + SW'(GRAN_BYTES) + rd_sz;
                     cur_in = prev_ff;
                  end else begin
                     acc_in = rd_sz;
                  end
                  // merged header written at end of forward merge
                  mem_we    = 1'b1;
                  mem_wdata = {rd_sz, 1'b0};
                  steps_in  = '0;
                  state_in  = ST_F_NX_RD;
               end
            end else begin
               prev_in      = cur_ff;
               prev_sz_in   = rd_sz;
               prev_free_in = !rd_alloc;
               have_prev_in = 1'b1;
               cur_in       = nxt;
               steps_in     = steps_ff + (IW + 1)'(1);
               state_in     = ST_F_RD;
            end
         end
         ST_F_NX_RD: begin
            split_in = cur_ff + GRAN_C + CW'(acc_ff);
            mem_addr = split_in[GRAN_SHIFT +: IW];
            if (split_in >= HEAP_END || steps_ff >= (IW + 1)'(SLOTS)) begin
               mem_we    = 1'b1;
               mem_addr  = cur_ff[GRAN_SHIFT +: IW];
               mem_wdata = {acc_ff, 1'b0};
               state_in  = ST_RESP;
            end else begin
               state_in = ST_F_NX_CHK;
            end
         end
         ST_F_NX_CHK: begin
            if (rd_alloc) begin
               mem_we    = 1'b1;
               mem_wdata = {acc_ff, 1'b0};
               state_in  = ST_RESP;
            end else begin
               acc_in   = acc_ff + SW'(GRAN_BYTES) + rd_sz;
               steps_in = steps_ff + (IW + 1)'(1);
               state_in = ST_F_NX_RD;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_offset = grant_ff;
   assign rsp_used_bytes     = bytes_ff;
   assign rsp_used_chunks    = chunks_ff;
endmodule
`default_nettype wire

>>> bench/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
   import ffha_pkg::*;

   localparam int HEAP = 4096;
   localparam int SLOT_COUNT = HEAP / GRAN_BYTES;
   localparam int IDLE_LIMIT = 20000;   // cycles with no transfer before giving up

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OP_ALLOC;
   logic [15:0] req_request_size = '0;
   logic [11:0] req_payload_offset = '0;
   logic        req_is_null = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_granted_offset;
   logic [11:0] rsp_used_bytes;
   logic [9:0]  rsp_used_chunks;

   first_fit_heap_allocator #(.HEAP_BYTES(HEAP)) i_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Expected response record
   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] granted;
      logic [11:0] bytes_used;
      logic [9:0]  chunks_used;
   } heap_rsp_type;

   heap_rsp_type expected_rsps[$];

   // Shadow heap: size and allocated mark per granule slot
   int unsigned chunk_size[SLOT_COUNT];
   bit          chunk_busy[SLOT_COUNT];
   int unsigned bytes_held;
   int unsigned chunks_held;
   int unsigned live_offsets[$];     // payload offsets currently granted

   int  error_count = 0;
   int  idle_cycles = 0;
   bit  hold_off = 1'b0;             // forces a long receiver stall
   bit  bursty_rsp = 1'b1;

   function automatic int unsigned next_chunk(int unsigned off);
      return off + GRAN_BYTES + chunk_size[off / GRAN_BYTES];
   endfunction

   function automatic void shadow_reset();
      foreach (chunk_size[i]) begin
         chunk_size[i] = 0;
         chunk_busy[i] = 1'b0;
      end
      chunk_size[0] = HEAP - GRAN_BYTES;
      bytes_held = 0;
      chunks_held = 0;
      live_offsets.delete();
   endfunction

   function automatic heap_rsp_type pack_rsp(logic [1:0] st, int unsigned granted);
      heap_rsp_type r;
      r.status      = st;
      r.granted     = granted[11:0];
      r.bytes_used  = bytes_held[11:0];
      r.chunks_used = chunks_held[9:0];
      return r;
   endfunction

   function automatic heap_rsp_type predict_alloc(int unsigned req);
      int unsigned want, cur, steps, old, kept;
      want = (req + GRAN_BYTES - 1) & ~(GRAN_BYTES - 1);
      cur = 0;
      steps = 0;
      while (cur < HEAP && steps < SLOT_COUNT) begin
         old = chunk_size[cur / GRAN_BYTES];
         if (!chunk_busy[cur / GRAN_BYTES] && old >= want) begin
            kept = old;
            if (old > want + GRAN_BYTES) begin
               kept = want;
               chunk_size[(cur + GRAN_BYTES + want) / GRAN_BYTES] = old - want - GRAN_BYTES;
               chunk_busy[(cur + GRAN_BYTES + want) / GRAN_BYTES] = 1'b0;
            end
            chunk_size[cur / GRAN_BYTES] = kept;
            chunk_busy[cur / GRAN_BYTES] = 1'b1;
            bytes_held += kept;
            chunks_held += 1;
            live_offsets.push_back(cur + GRAN_BYTES);
            return pack_rsp(STATUS_OK, cur + GRAN_BYTES);
         end
         cur = next_chunk(cur);
         steps++;
      end
      return pack_rsp(STATUS_NOSPACE, 0);
   endfunction

   function automatic heap_rsp_type predict_free(int unsigned pay);
      int unsigned cur, prev, steps, target, sz, nx;
      bit found, have_prev;
      cur = 0; prev = 0; steps = 0;
      found = 1'b0; have_prev = 1'b0;
      if (pay < GRAN_BYTES || pay >= HEAP) return pack_rsp(STATUS_BADPTR, 0);
      target = pay - GRAN_BYTES;
      while (cur < HEAP && steps < SLOT_COUNT) begin
         if (cur == target) begin
            found = 1'b1;
            break;
         end
         prev = cur;
         have_prev = 1'b1;
         cur = next_chunk(cur);
         steps++;
      end
      if (!found || !chunk_busy[target / GRAN_BYTES]) return pack_rsp(STATUS_BADPTR, 0);
      sz = chunk_size[target / GRAN_BYTES];
      bytes_held -= sz;
      chunks_held -= 1;
      chunk_busy[target / GRAN_BYTES] = 1'b0;
      foreach (live_offsets[i]) begin
         if (live_offsets[i] == pay) begin
            live_offsets.delete(i);
            break;
         end
      end
      if (have_prev && !chunk_busy[prev / GRAN_BYTES]) begin
         chunk_size[prev / GRAN_BYTES] += GRAN_BYTES + sz;
         target = prev;
      end
      steps = 0;
      forever begin
         nx = next_chunk(target);
         if (nx >= HEAP || steps >= SLOT_COUNT) break;
         if (chunk_busy[nx / GRAN_BYTES]) break;
         chunk_size[target / GRAN_BYTES] += GRAN_BYTES + chunk_size[nx / GRAN_BYTES];
         steps++;
      end
      return pack_rsp(STATUS_OK, 0);
   endfunction

   function automatic heap_rsp_type predict_heap_op(logic op, logic [15:0] sz,
                                                    logic [11:0] pay, logic nul);
      if (op == OP_ALLOC) return predict_alloc(sz);
      if (nul) return pack_rsp(STATUS_OK, 0);
      return predict_free(pay);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Send one request; valid stays up until the transfer happens
   task automatic send_heap_op(logic op, logic [15:0] sz, logic [11:0] pay, logic nul);
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_request_size   <= sz;
      req_payload_offset <= pay;
      req_is_null        <= nul;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(predict_heap_op(op, sz, pay, nul));
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Bursty sender helpers
   int burst_left = 0;
   task automatic paced_send(logic op, logic [15:0] sz, logic [11:0] pay, logic nul);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) pause_sender();
      end
      burst_left--;
      send_heap_op(op, sz, pay, nul);
   endtask

   task automatic send_alloc(int unsigned sz);
      paced_send(OP_ALLOC, sz[15:0], 12'($urandom()), 1'($urandom()));
   endtask

   task automatic send_free(int unsigned pay);
      paced_send(OP_FREE, 16'($urandom()), pay[11:0], 1'b0);
   endtask

   // Response checker
   always @(posedge clock) begin
      heap_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_granted_offset !== want.granted)
               report_mismatch("granted_offset", rsp_granted_offset, want.granted);
            if (rsp_used_bytes !== want.bytes_used)
               report_mismatch("used_bytes", rsp_used_bytes, want.bytes_used);
            if (rsp_used_chunks !== want.chunks_used)
               report_mismatch("used_chunks", rsp_used_chunks, want.chunks_used);
         end
      end
   end

   // Receiver: own stall pattern, plus stretches of always-ready
   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else if (!bursty_rsp) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 999) == 0) bursty_rsp <= ~bursty_rsp;
   end

   // Watchdog: counts cycles with no transfer on either channel, outside hold-off
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Directed: boundary sizes, zero size, no-split remainder, oversize
   task automatic test_alloc_edges();
      send_alloc(0);            // zero size splits off the rest
      send_alloc(1);
      send_alloc(8);
      send_alloc(9);
      send_alloc(16'hFFFF);     // oversize
      send_alloc(4089);         // oversize by one granule
      send_free(8);             // first chunk
      send_free(8);             // already free
      send_alloc(0);            // refills the zero-size hole
   endtask

   // Directed: bad pointer cases and null free
   task automatic test_free_errors();
      paced_send(OP_FREE, 16'h0, 12'd0, 1'b0);     // below one header
      paced_send(OP_FREE, 16'h0, 12'd4095, 1'b0);  // at heap end region
      paced_send(OP_FREE, 16'h0, 12'd20, 1'b0);    // not a chunk start
      paced_send(OP_FREE, 16'hFFFF, 12'hFFF, 1'b1);// null free
      paced_send(OP_FREE, 16'h0, 12'd0, 1'b1);
   endtask

   // Directed: merge with neighbors on both sides, then a full-heap grab
   task automatic test_merging();
      while (live_offsets.size() > 0) send_free(live_offsets[0]);
      send_alloc(24);
      send_alloc(40);
      send_alloc(64);
      send_free(live_offsets[0]);
      send_free(live_offsets[0]);   // merges with the free chunk before it
      send_free(live_offsets[0]);   // merges forward into the tail
      send_alloc(4088);             // whole heap in one chunk
      send_alloc(0);                // nothing left
      send_free(live_offsets[0]);
   endtask

   // Random: mostly frees of live chunks and small allocates
   task automatic test_random_traffic(int n);
      int unsigned pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            case ($urandom_range(0, 9))
               0:       send_alloc($urandom());
               1:       send_alloc($urandom_range(0, 4095));
               2:       send_alloc($urandom_range(1000, 2100));
               default: send_alloc($urandom_range(0, 96));
            endcase
         end else if (pick < 85 && live_offsets.size() > 0) begin
            send_free(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
         end else if (pick < 92) begin
            paced_send(OP_FREE, 16'($urandom()), 12'($urandom()), 1'b0);
         end else begin
            paced_send(OP_FREE, 16'($urandom()), 12'($urandom()), 1'b1);
         end
      end
   endtask

   // Receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random_traffic(30);
      join
   endtask

   initial begin
      shadow_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_alloc_edges();
      test_free_errors();
      test_merging();
      test_random_traffic(250);
      test_backpressure();
      test_random_traffic(240);
      req_valid <= 1'b0;
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
